@@ rtl/crtc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crtc_pkg
// Types, register indexes, request codes and helper functions of the CRT
// controller timing block.
// ----------------------------------------------------------------------------
package crtc_pkg;

    // Request kinds.
    localparam logic [2:0] KIND_SELECT      = 3'd0;
    localparam logic [2:0] KIND_WRITE       = 3'd1;
    localparam logic [2:0] KIND_READ_DATA   = 3'd2;
    localparam logic [2:0] KIND_READ_STATUS = 3'd3;
    localparam logic [2:0] KIND_TICK        = 3'd4;

    // Controller variants.
    localparam logic [1:0] CTYPE_0 = 2'd0;
    localparam logic [1:0] CTYPE_1 = 2'd1;
    localparam logic [1:0] CTYPE_2 = 2'd2;
    localparam logic [1:0] CTYPE_3 = 2'd3;

    // Configuration register indexes on the APB port.
    localparam logic CFG_CTYPE = 1'b0;

    // Internal register file indexes.
    localparam int unsigned NUM_REGS = 16;
    localparam logic [3:0] R_HTOTAL     = 4'd0;
    localparam logic [3:0] R_HDISP      = 4'd1;
    localparam logic [3:0] R_HSYNC_POS  = 4'd2;
    localparam logic [3:0] R_SYNC_WIDTH = 4'd3;
    localparam logic [3:0] R_VTOTAL     = 4'd4;
    localparam logic [3:0] R_VADJ       = 4'd5;
    localparam logic [3:0] R_VDISP      = 4'd6;
    localparam logic [3:0] R_VSYNC_POS  = 4'd7;
    localparam logic [3:0] R_MODE       = 4'd8;
    localparam logic [3:0] R_MAX_RASTER = 4'd9;
    localparam logic [3:0] R_CUR_START  = 4'd10;
    localparam logic [3:0] R_CUR_END    = 4'd11;
    localparam logic [3:0] R_START_HI   = 4'd12;
    localparam logic [3:0] R_START_LO   = 4'd13;
    localparam logic [3:0] R_CUR_HI     = 4'd14;
    localparam logic [3:0] R_CUR_LO     = 4'd15;

    // Selected register numbers that matter for reads.
    localparam logic [4:0] SEL_FIRST_START  = 5'd12;
    localparam logic [4:0] SEL_FIRST_CURSOR = 5'd14;
    localparam logic [4:0] SEL_LAST_READ    = 5'd17;
    localparam logic [4:0] SEL_ALL_ONES     = 5'd31;

    // Write masks and read constants.
    localparam logic [7:0] MASK_7BIT   = 8'h7F;
    localparam logic [7:0] MASK_5BIT   = 8'h1F;
    localparam logic [7:0] MASK_6BIT   = 8'h3F;
    localparam logic [7:0] MASK_2BIT   = 8'h03;
    localparam logic [7:0] STATUS_VBLK = 8'h20;
    localparam logic [7:0] BYTE_ONES   = 8'hFF;

    // Reset values of the register file.
    localparam logic [7:0] REG_DEFAULT [NUM_REGS] = '{
        8'd63, 8'd40, 8'd46, 8'h8E, 8'd38, 8'd0, 8'd25, 8'd30,
        8'd0,  8'd7,  8'd0,  8'd0,  8'h30, 8'd0, 8'd0,  8'd0
    };

    localparam logic [13:0] START_ADDR_RESET = 14'h3000;

    // One request on the input channel.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } crtc_req_t;

    // One result on the output channel.
    typedef struct packed {
        logic [7:0]  read_data;
        logic [15:0] address;
        logic [4:0]  raster_line;
        logic        disp_on;
        logic        hsync;
        logic        vsync;
        logic        line_done;
        logic        mode_pulse;
    } crtc_rsp_t;

    // Status flags of the timing state.
    typedef struct packed {
        logic hdisp;
        logic vdisp;
        logic de;
        logic hsync;
        logic vsync;
        logic vadj;
        logic lastras;
        logic lastfrm;
        logic latched;
    } crtc_flags_t;

    // Applies the per-register write mask for the given controller variant.
    function automatic logic [7:0] mask_value(input logic [3:0] r, input logic [7:0] v,
                                              input logic [1:0] ctype);
        logic [7:0] res;
        begin
            case (r)
                R_VTOTAL, R_VDISP, R_VSYNC_POS, R_CUR_START: res = v & MASK_7BIT;
                R_VADJ, R_MAX_RASTER, R_CUR_END:             res = v & MASK_5BIT;
                R_MODE:
                begin
                    if (ctype == CTYPE_1 || ctype == CTYPE_2)
                    begin
                        res = v & MASK_2BIT;
                    end
                    else
                    begin
                        res = v;
                    end
                end
                R_START_HI, R_CUR_HI:                        res = v & MASK_6BIT;
                default:                                     res = v;
            endcase
            return res;
        end
    endfunction

endpackage

@@ rtl/crt_controller_timing.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crt_controller_timing
// 6845-style CRT controller: register select, masked writes, data and status
// reads, and character-clock ticks that drive the raster timing counters.
// ----------------------------------------------------------------------------
//
//  Channel  | Signals                               | Direction | Payload
//  ---------+---------------------------------------+-----------+------------
//  request  | req_valid, req_stall, req             | in        | crtc_req_t
//  result   | rsp_valid, rsp_stall, rsp             | out       | crtc_rsp_t
//  config   | psel, penable, pwrite, paddr, pwdata, | in/out    | APB, 32 bit
//           | prdata, pready                        |           |
//
//  Each request is handled at once: the timing state and the result are
//  computed from the state registers and written at the accepting edge.
//  The result goes to the result register, or to the skid register while
//  a stalled result waits. A request can be taken in every cycle while
//  req_stall is low; the two-slot output keeps the input open for one more
//  request while a result waits. req_stall rises only when both output slots
//  are full. Reset loads the default register values, clears the counters
//  and sets the start address to 0x3000; no clearing pass is needed.
// ----------------------------------------------------------------------------
module crt_controller_timing (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_stall,
    input  crtc_pkg::crtc_req_t  req,
    output logic                 rsp_valid,
    input  logic                 rsp_stall,
    output crtc_pkg::crtc_rsp_t  rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // State registers.
    logic [1:0]             ctype_reg;
    logic [7:0]             regs_reg [crtc_pkg::NUM_REGS];
    logic [7:0]             regs_next [crtc_pkg::NUM_REGS];
    logic [4:0]             sel_reg, sel_next;
    logic [7:0]             char_reg, char_next;
    logic [6:0]             row_reg, row_next;
    logic [4:0]             raster_reg, raster_next;
    logic [5:0]             acnt_reg, acnt_next;
    logic [4:0]             hcnt_reg, hcnt_next;
    logic [4:0]             vcnt_reg, vcnt_next;
    logic [15:0]            addr_reg, addr_next;
    logic [13:0]            rsa_reg, rsa_next;
    logic [13:0]            nra_reg, nra_next;
    crtc_pkg::crtc_flags_t  flags_reg, flags_next;

    // Output slots.
    logic                   rsp_valid_reg;
    logic                   skid_valid_reg;
    crtc_pkg::crtc_rsp_t    rsp_reg;
    crtc_pkg::crtc_rsp_t    skid_reg;
    crtc_pkg::crtc_rsp_t    result;

    // Handshake and derived values.
    logic                   accept;
    logic                   out_take;
    logic                   cfg_wr;
    logic [1:0]             ctype_new;
    logic [4:0]             hsw;
    logic [4:0]             vsw;
    logic [13:0]            start_addr;
    logic                   eol;
    logic                   hdisp_zero;
    logic [7:0]             sel_value;
    logic [7:0]             read_reg_value;
    logic [7:0]             read_status_value;
    logic [7:0]             wval;
    logic [7:0]             rd;
    logic                   nl;
    logic                   ml;

    // Handshakes.
    assign req_stall = skid_valid_reg;
    assign accept    = req_valid && !skid_valid_reg;
    assign out_take  = rsp_valid_reg && !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // APB configuration port.
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && (paddr[2] == crtc_pkg::CFG_CTYPE);
    assign ctype_new = pwdata[1:0];
    assign prdata    = (paddr[2] == crtc_pkg::CFG_CTYPE) ? {30'd0, ctype_reg} : 32'd0;

    // Sync widths and start address from the current registers.
    always_comb
    begin
        if (regs_reg[crtc_pkg::R_SYNC_WIDTH][3:0] == 4'd0 &&
            (ctype_reg == crtc_pkg::CTYPE_2 || ctype_reg == crtc_pkg::CTYPE_3))
        begin
            hsw = 5'd16;
        end
        else
        begin
            hsw = {1'b0, regs_reg[crtc_pkg::R_SYNC_WIDTH][3:0]};
        end
        if (ctype_reg == crtc_pkg::CTYPE_0 || ctype_reg == crtc_pkg::CTYPE_3)
        begin
            if (regs_reg[crtc_pkg::R_SYNC_WIDTH][7:4] == 4'd0)
            begin
                vsw = 5'd16;
            end
            else
            begin
                vsw = {1'b0, regs_reg[crtc_pkg::R_SYNC_WIDTH][7:4]};
            end
        end
        else
        begin
            vsw = 5'd16;
        end
    end

    assign start_addr = {regs_reg[crtc_pkg::R_START_HI][5:0], regs_reg[crtc_pkg::R_START_LO]};
    assign eol        = (char_reg == regs_reg[crtc_pkg::R_HTOTAL]);
    assign hdisp_zero = (regs_reg[crtc_pkg::R_HDISP] == 8'd0);

    // Register and status reads.
    always_comb
    begin
        sel_value = sel_reg[4] ? 8'd0 : regs_reg[sel_reg[3:0]];
        if (ctype_reg == crtc_pkg::CTYPE_0 || ctype_reg == crtc_pkg::CTYPE_3)
        begin
            read_reg_value = (sel_reg >= crtc_pkg::SEL_FIRST_START &&
                              sel_reg <= crtc_pkg::SEL_LAST_READ) ? sel_value : 8'd0;
        end
        else if (sel_reg >= crtc_pkg::SEL_FIRST_CURSOR && sel_reg <= crtc_pkg::SEL_LAST_READ)
        begin
            read_reg_value = sel_value;
        end
        else if (ctype_reg == crtc_pkg::CTYPE_1 && sel_reg == crtc_pkg::SEL_ALL_ONES)
        begin
            read_reg_value = crtc_pkg::BYTE_ONES;
        end
        else
        begin
            read_reg_value = 8'd0;
        end

        if (ctype_reg == crtc_pkg::CTYPE_1)
        begin
            read_status_value = ({1'b0, row_reg} >= regs_reg[crtc_pkg::R_VDISP]) ?
                                crtc_pkg::STATUS_VBLK : 8'd0;
        end
        else if (ctype_reg == crtc_pkg::CTYPE_3)
        begin
            read_status_value = read_reg_value;
        end
        else
        begin
            read_status_value = crtc_pkg::BYTE_ONES;
        end
    end

    assign wval = crtc_pkg::mask_value(sel_reg[3:0], req.data, ctype_reg);

    // Next timing state for the accepted request.
    always_comb
    begin
        regs_next   = regs_reg;
        sel_next    = sel_reg;
        char_next   = char_reg;
        row_next    = row_reg;
        raster_next = raster_reg;
        acnt_next   = acnt_reg;
        hcnt_next   = hcnt_reg;
        vcnt_next   = vcnt_reg;
        addr_next   = addr_reg;
        rsa_next    = rsa_reg;
        nra_next    = nra_reg;
        flags_next  = flags_reg;
        rd          = 8'd0;
        nl          = 1'b0;
        ml          = 1'b0;

        if (accept)
        begin
            case (req.kind)
                crtc_pkg::KIND_SELECT:
                begin
                    sel_next = req.data[4:0];
                end
                crtc_pkg::KIND_WRITE:
                begin
                    // Writes above R15 are dropped.
                    if (!sel_reg[4])
                    begin
                        regs_next[sel_reg[3:0]] = wval;
                        if (sel_reg[3:0] == crtc_pkg::R_VDISP && {1'b0, row_reg} == wval)
                        begin
                            flags_next.vdisp = 1'b0;
                        end
                        if ((sel_reg[3:0] == crtc_pkg::R_VTOTAL ||
                             sel_reg[3:0] == crtc_pkg::R_MAX_RASTER) && char_reg <= 8'd1)
                        begin
                            flags_next.lastras = ({3'b0, raster_reg} ==
                                                  regs_next[crtc_pkg::R_MAX_RASTER]);
                            flags_next.lastfrm = flags_next.lastras &&
                                ({1'b0, row_reg} == regs_next[crtc_pkg::R_VTOTAL]);
                        end
                        flags_next.de = flags_next.hdisp && flags_next.vdisp;
                    end
                end
                crtc_pkg::KIND_READ_DATA:
                begin
                    rd = read_reg_value;
                end
                crtc_pkg::KIND_READ_STATUS:
                begin
                    rd = read_status_value;
                end
                crtc_pkg::KIND_TICK:
                begin
                    char_next = char_reg + 8'd1;
                    addr_next = addr_reg + 16'd1;

                    // Horizontal sync start, width count and mode latch pulse.
                    if (hsw != 5'd0 && !flags_reg.hsync &&
                        char_next == regs_reg[crtc_pkg::R_HSYNC_POS])
                    begin
                        flags_next.hsync   = 1'b1;
                        hcnt_next          = 5'd0;
                        flags_next.latched = 1'b0;
                    end
                    if (flags_next.hsync)
                    begin
                        if (hcnt_next == hsw)
                        begin
                            flags_next.hsync = 1'b0;
                            if (!flags_next.latched)
                            begin
                                ml                 = 1'b1;
                                flags_next.latched = 1'b1;
                            end
                        end
                        else
                        begin
                            hcnt_next = hcnt_next + 5'd1;
                            if (hsw < 5'd16)
                            begin
                                hcnt_next[4] = 1'b0;
                            end
                            if (hcnt_next == 5'd7 && !flags_next.latched)
                            begin
                                ml                 = 1'b1;
                                flags_next.latched = 1'b1;
                            end
                        end
                    end

                    // Capture the next row address on the last raster line.
                    if (flags_reg.lastras &&
                        (char_next == regs_reg[crtc_pkg::R_HDISP] || (eol && hdisp_zero)))
                    begin
                        nra_next = (eol && hdisp_zero) ? rsa_reg : addr_next[13:0];
                    end

                    if (eol)
                    begin
                        nl               = 1'b1;
                        char_next        = 8'd0;
                        flags_next.hdisp = !hdisp_zero;

                        // Vertical sync width count.
                        if (flags_reg.vsync)
                        begin
                            vcnt_next = vcnt_reg + 5'd1;
                            if (vcnt_next >= vsw)
                            begin
                                flags_next.vsync = 1'b0;
                            end
                        end

                        // Vertical adjust, row and raster advance.
                        if (flags_reg.vadj)
                        begin
                            acnt_next = acnt_reg + 6'd1;
                            if ({2'b0, acnt_next} > regs_reg[crtc_pkg::R_VADJ])
                            begin
                                flags_next.vadj  = 1'b0;
                                acnt_next        = 6'd0;
                                row_next         = 7'd0;
                                raster_next      = 5'd0;
                                rsa_next         = start_addr;
                                nra_next         = start_addr;
                                flags_next.vdisp = (regs_reg[crtc_pkg::R_VDISP] != 8'd0);
                            end
                        end
                        else if (flags_reg.lastras)
                        begin
                            raster_next = 5'd0;
                            if (flags_reg.lastfrm)
                            begin
                                if (regs_reg[crtc_pkg::R_VADJ] != 8'd0)
                                begin
                                    flags_next.vadj = 1'b1;
                                    acnt_next       = 6'd0;
                                end
                                else
                                begin
                                    row_next         = 7'd0;
                                    rsa_next         = start_addr;
                                    nra_next         = start_addr;
                                    flags_next.vdisp = (regs_reg[crtc_pkg::R_VDISP] != 8'd0);
                                end
                            end
                            else
                            begin
                                row_next = row_reg + 7'd1;
                                if ({1'b0, row_next} == regs_reg[crtc_pkg::R_VDISP])
                                begin
                                    flags_next.vdisp = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            raster_next = raster_reg + 5'd1;
                        end

                        // Variant 1 reloads the start address on every line of row zero.
                        if (ctype_reg == crtc_pkg::CTYPE_1 && row_next == 7'd0)
                        begin
                            rsa_next = start_addr;
                            nra_next = start_addr;
                        end
                        rsa_next  = nra_next;
                        addr_next = {2'b0, nra_next};

                        flags_next.lastras = ({3'b0, raster_next} ==
                                              regs_reg[crtc_pkg::R_MAX_RASTER]);
                        flags_next.lastfrm = flags_next.lastras &&
                            ({1'b0, row_next} == regs_reg[crtc_pkg::R_VTOTAL]);
                    end
                    else if (char_next == regs_reg[crtc_pkg::R_HDISP])
                    begin
                        flags_next.hdisp = 1'b0;
                    end

                    // Vertical sync start.
                    if ({1'b0, row_next} == regs_reg[crtc_pkg::R_VSYNC_POS] &&
                        !flags_next.vsync)
                    begin
                        flags_next.vsync = 1'b1;
                        vcnt_next        = 5'd0;
                    end
                    flags_next.de = flags_next.hdisp && flags_next.vdisp;
                end
                default:
                begin
                    // Unknown kinds leave the state alone.
                end
            endcase
        end

        // A variant change re-masks the mode register.
        if (cfg_wr)
        begin
            regs_next[crtc_pkg::R_MODE] = crtc_pkg::mask_value(crtc_pkg::R_MODE,
                                              regs_next[crtc_pkg::R_MODE], ctype_new);
        end
    end

    // Result of the accepted request.
    always_comb
    begin
        result.read_data   = rd;
        result.address     = addr_next;
        result.raster_line = raster_next;
        result.disp_on     = flags_next.de;
        result.hsync       = flags_next.hsync;
        result.vsync       = flags_next.vsync;
        result.line_done   = nl;
        result.mode_pulse  = ml;
    end

    // Timing state update.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctype_reg  <= crtc_pkg::CTYPE_1;
            regs_reg   <= crtc_pkg::REG_DEFAULT;
            sel_reg    <= 5'd0;
            char_reg   <= 8'd0;
            row_reg    <= 7'd0;
            raster_reg <= 5'd0;
            acnt_reg   <= 6'd0;
            hcnt_reg   <= 5'd0;
            vcnt_reg   <= 5'd0;
            addr_reg   <= {2'b0, crtc_pkg::START_ADDR_RESET};
            rsa_reg    <= crtc_pkg::START_ADDR_RESET;
            nra_reg    <= crtc_pkg::START_ADDR_RESET;
            flags_reg  <= '{hdisp: 1'b1, vdisp: 1'b1, de: 1'b1, default: 1'b0};
        end
        else
        begin
            if (cfg_wr)
            begin
                ctype_reg <= ctype_new;
            end
            regs_reg   <= regs_next;
            sel_reg    <= sel_next;
            char_reg   <= char_next;
            row_reg    <= row_next;
            raster_reg <= raster_next;
            acnt_reg   <= acnt_next;
            hcnt_reg   <= hcnt_next;
            vcnt_reg   <= vcnt_next;
            addr_reg   <= addr_next;
            rsa_reg    <= rsa_next;
            nra_reg    <= nra_next;
            flags_reg  <= flags_next;
        end
    end

    // Output slot control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (!rsp_valid_reg || out_take)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Output slot payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (!rsp_valid_reg || out_take)
            begin
                rsp_reg <= result;
            end
            else
            begin
                skid_reg <= result;
            end
        end
        else if (out_take && skid_valid_reg)
        begin
            rsp_reg <= skid_reg;
        end
    end

    // The skid slot only fills behind a waiting result.
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> rsp_valid_reg)
        else $error("skid slot holds a result while the result slot is empty");

    // Display enable always tracks both display flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg.de == (flags_reg.hdisp && flags_reg.vdisp))
        else $error("display enable out of step with display flags");

    // An accepted request always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted request produced no result");

    // At the end of a line the address counter restarts at the row start.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.kind == crtc_pkg::KIND_TICK &&
         char_reg == regs_reg[crtc_pkg::R_HTOTAL])
        |=> addr_reg == {2'b0, rsa_reg})
        else $error("address counter not reloaded at end of line");

endmodule
